// ===== rtl/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// MD5 package
// Round constants, rotate amounts, message schedule index and shared types.
// ----------------------------------------------------------------------------
package md5_pkg;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   // datapath commands from the controller
   typedef struct packed {
      logic       wr_byte;     // write req byte at fill position
      logic       pad_write;   // write pad byte at pad_addr
      logic [5:0] pad_addr;
      logic [7:0] pad_data;
      logic       rd_en;       // read word for round
      logic [3:0] rd_word;
      logic       round_en;    // run one round
      logic [5:0] round_idx;
      logic       load_work;   // copy chain into working regs
      logic       fold;        // add working regs into chain
      logic       chain_init;  // restore initial chain
   } cmd_type;

   function automatic logic [31:0] round_const(input logic [5:0] i);
      logic [31:0] k [64];
      k = '{
         32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
         32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
         32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
         32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
         32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
         32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
         32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
         32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
         32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
         32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
         32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
      return k[i];
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] i);
      logic [4:0] r [16];
      r = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
            5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
      return r[{i[5:4], i[1:0]}];
   endfunction

   // message word used by round i (mod 16 is the low four bits)
   function automatic logic [3:0] msg_index(input logic [5:0] i);
      logic [3:0] g;
      unique case (i[5:4])
         2'd0: g = i[3:0];
         2'd1: g = 4'(5 * i[3:0] + 1);
         2'd2: g = 4'(3 * i[3:0] + 5);
         2'd3: g = 4'(7 * i[3:0]);
         default: g = i[3:0];
      endcase
      return g;
   endfunction

endpackage

// ===== rtl/md5_ram.sv =====
// ----------------------------------------------------------------------------
// MD5 generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module md5_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/md5_datapath.sv =====
// ----------------------------------------------------------------------------
// MD5 datapath
// Block buffer (four byte lanes), working registers, one round per cycle.
// ----------------------------------------------------------------------------
module md5_datapath (
   input  logic           clock,
   input  md5_pkg::cmd_type cmd,
   input  logic [5:0]     fill,
   input  logic [7:0]     data_byte,
   output logic [31:0]    chain_a,
   output logic [31:0]    chain_b,
   output logic [31:0]    chain_c,
   output logic [31:0]    chain_d
);
   import md5_pkg::*;

   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] h0_ff, h1_ff, h2_ff, h3_ff;
   logic [31:0] word;
   logic [31:0] f, sum;
   logic [4:0]  rot;
   logic [5:0]  waddr;
   logic [7:0]  wdata;
   logic        wen;
   logic [63:0] sum64;

   assign wen   = cmd.wr_byte | cmd.pad_write;
   assign waddr = cmd.pad_write ? cmd.pad_addr : fill;
   assign wdata = cmd.pad_write ? cmd.pad_data : data_byte;

   // one RAM per byte lane, so a whole little-endian word is read in a single access
   for (genvar ln = 0; ln < 4; ln++) begin : g_lane
      md5_ram #(.Width(8), .Depth(16)) u_lane (
         .clock   (clock),
         .wr_en   (wen && (waddr[1:0] == 2'(ln))),
         .wr_addr (waddr[5:2]),
         .wr_data (wdata),
         .rd_en   (cmd.rd_en),
         .rd_addr (cmd.rd_word),
         .rd_data (word[8*ln +: 8])
      );
   end

   always_comb begin
      unique case (cmd.round_idx[5:4])
         2'd0: f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2: f = b_ff ^ c_ff ^ d_ff;
         2'd3: f = c_ff ^ (b_ff | ~d_ff);
         default: f = '0;
      endcase
      rot   = rot_amount(cmd.round_idx);
      sum   = a_ff + f + round_const(cmd.round_idx) + word;
      sum64 = {sum, sum} << rot;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_work) begin
         a_ff <= h0_ff; b_ff <= h1_ff; c_ff <= h2_ff; d_ff <= h3_ff;
      end else if (cmd.round_en) begin
         a_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= b_ff;
         b_ff <= b_ff + sum64[63:32];
      end
      if (cmd.chain_init) begin
         h0_ff <= INIT_A; h1_ff <= INIT_B; h2_ff <= INIT_C; h3_ff <= INIT_D;
      end else if (cmd.fold) begin
         h0_ff <= h0_ff + a_ff; h1_ff <= h1_ff + b_ff;
         h2_ff <= h2_ff + c_ff; h3_ff <= h3_ff + d_ff;
      end
   end

   assign chain_a = h0_ff;
   assign chain_b = h1_ff;
   assign chain_c = h2_ff;
   assign chain_d = h3_ff;
endmodule

// ===== rtl/md5_control.sv =====
// ----------------------------------------------------------------------------
// MD5 controller
// Byte intake, padding sequence, round sequencing and digest output.
// ----------------------------------------------------------------------------
module md5_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             has_byte,
   input  logic             end_of_message,
   output md5_pkg::cmd_type cmd,
   output logic [5:0]       fill,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [1:0]       out_index
);
   import md5_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PAD   = 3'd1;  // write padding bytes
   localparam logic [2:0] S_LOAD  = 3'd2;
   localparam logic [2:0] S_ROUND = 3'd3;
   localparam logic [2:0] S_FOLD  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] len_ff, len_in;
   logic [5:0]  idx_ff, idx_in;        // pad address or round number
   logic        fin_ff, fin_in;        // closing message
   logic        two_ff, two_in;        // second pad block pending
   logic [1:0]  oidx_ff, oidx_in;
   logic        pad_done_ff;           // padding block already run for this message
   logic        accept;
   logic [63:0] bits;
   logic [5:0]  lpos;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign fill      = fill_ff;
   assign out_valid = (state_ff == S_OUT);
   assign out_index = oidx_ff;
   assign bits      = {len_ff[60:0], 3'b000};
   assign lpos      = idx_ff - 6'd56;

   always_comb begin
      state_in = state_ff; fill_in = fill_ff; len_in = len_ff;
      idx_in = idx_ff; fin_in = fin_ff; two_in = two_ff; oidx_in = oidx_ff;
      cmd = '0;
      cmd.round_idx = idx_ff;
      cmd.rd_word   = msg_index(idx_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.wr_byte = has_byte;
               if (has_byte) begin
                  fill_in = fill_ff + 6'd1;
                  len_in  = len_ff + 64'd1;
               end
               fin_in = end_of_message;
               if (has_byte && fill_ff == 6'd63) begin
                  state_in = S_LOAD;
               end else if (end_of_message) begin
                  state_in = S_PAD;
                  idx_in   = has_byte ? fill_ff + 6'd1 : fill_ff;
               end
            end
         end
         S_PAD: begin
            // one byte per cycle from idx to 63
            cmd.pad_write = 1'b1;
            cmd.pad_addr  = idx_ff;
            if (idx_ff == fill_ff && !two_ff && !(fill_ff == 6'd0 && fin_ff == 1'b0))
               cmd.pad_data = 8'h80;
            else if (idx_ff >= 6'd56 && !(fill_ff >= 6'd56 && !two_ff))
               cmd.pad_data = bits[8*lpos[2:0] +: 8];
            else
               cmd.pad_data = 8'h00;
            idx_in = idx_ff + 6'd1;
            if (idx_ff == 6'd63) begin
               state_in = S_LOAD;
               two_in   = (fill_ff >= 6'd56) && !two_ff;
            end
         end
         S_LOAD: begin
            cmd.load_work = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_word   = msg_index(6'd0);
            idx_in        = 6'd0;
            state_in      = S_ROUND;
         end
         S_ROUND: begin
            cmd.round_en = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.rd_word  = msg_index(idx_ff + 6'd1);
            idx_in       = idx_ff + 6'd1;
            if (idx_ff == 6'd63) state_in = S_FOLD;
         end
         S_FOLD: begin
            cmd.fold = 1'b1;
            if (!fin_ff) begin
               fill_in  = 6'd0;
               state_in = S_IDLE;
            end else if (two_ff || !pad_done_ff) begin
               // second pad block, or 64th byte with end: pad a fresh block
               idx_in   = 6'd0;
               state_in = S_PAD;
            end else begin
               oidx_in  = 2'd0;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_ready) begin
               oidx_in = oidx_ff + 2'd1;
               if (oidx_ff == 2'd3) begin
                  cmd.chain_init = 1'b1;
                  fill_in = 6'd0; len_in = '0; fin_in = 1'b0; two_in = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (reset) cmd.chain_init = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; fill_ff <= '0; len_ff <= '0; idx_ff <= '0;
         fin_ff <= 1'b0; two_ff <= 1'b0; oidx_ff <= '0;
      end else begin
         state_ff <= state_in; fill_ff <= fill_in; len_ff <= len_in; idx_ff <= idx_in;
         fin_ff <= fin_in; two_ff <= two_in; oidx_ff <= oidx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) pad_done_ff <= 1'b0;
      else if (state_ff == S_PAD) pad_done_ff <= 1'b1;
      else if (state_ff == S_IDLE) pad_done_ff <= 1'b0;
   end
endmodule

// ===== rtl/md5_message_digest.sv =====
// ----------------------------------------------------------------------------
// MD5 message digest
// Byte-serial MD5: buffers bytes into 64-byte blocks and compresses them.
// ----------------------------------------------------------------------------
// Flow: a byte item is written to the block buffer as it is accepted; the 64th byte
//   of a block starts compression (load, the rounds at one per cycle, fold).
// End of message: padding writes one byte per cycle, then a compression (load,
//   rounds, fold), once or twice, then four digest items, one per accepted cycle.
// Reset clears the controller and reloads the initial chaining values.
// ----------------------------------------------------------------------------
module md5_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import md5_pkg::*;

   cmd_type     cmd;
   logic [5:0]  fill;
   logic [31:0] ca, cb, cc, cd;
   logic [1:0]  oidx;

   md5_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready,
      .has_byte       (req_has_byte),
      .end_of_message (req_end_of_message),
      .cmd, .fill,
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_index (oidx)
   );

   md5_datapath u_dp (
      .clock, .cmd, .fill,
      .data_byte (req_data_byte),
      .chain_a (ca), .chain_b (cb), .chain_c (cc), .chain_d (cd)
   );

   // digest word select
   always_comb begin
      unique case (oidx)
         2'd0: rsp_digest_word = ca;
         2'd1: rsp_digest_word = cb;
         2'd2: rsp_digest_word = cc;
         2'd3: rsp_digest_word = cd;
         default: rsp_digest_word = ca;
      endcase
   end
   assign rsp_word_index = oidx;
   assign rsp_last_word  = (oidx == 2'd3);

   // no intake while the digest goes out
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("intake during output");
   // digest words go out in order
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word |=> rsp_valid &&
      rsp_word_index == $past(rsp_word_index) + 2'd1) else $error("word order");
   // last word ends the output phase
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_word |=> !rsp_valid) else $error("extra word");
endmodule

// ===== bench/tb_md5_message_digest.sv =====
// ----------------------------------------------------------------------------
// MD5 message digest testbench
// Streams messages of random and boundary lengths byte by byte, predicts the
// four digest words of each message in a scoreboard and checks every result.
// ----------------------------------------------------------------------------

class md5_digest_scoreboard;
   logic [31:0] chain [4];
   logic [7:0]  buffer [64];
   int unsigned fill;
   logic [63:0] msg_len;
   logic [31:0] digest_q [$];
   logic [1:0]  index_q [$];
   logic        last_q [$];
   int unsigned errors;

   function new();
      errors = 0;
      restart();
   endfunction

   function void restart();
      chain[0] = md5_pkg::INIT_A;
      chain[1] = md5_pkg::INIT_B;
      chain[2] = md5_pkg::INIT_C;
      chain[3] = md5_pkg::INIT_D;
      fill = 0;
      msg_len = '0;
   endfunction

   function void compress(input logic [7:0] blk [64]);
      logic [31:0] k [64];
      int unsigned rot [16];
      logic [31:0] m [16];
      logic [31:0] a, b, c, d, f, t, s;
      int unsigned g, r;
      k = '{
         32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
         32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
         32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
         32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
         32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
         32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
         32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
         32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
         32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
         32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
         32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
      rot = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      for (int i = 0; i < 16; i++)
         m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      for (int i = 0; i < 64; i++) begin
         if (i < 16) begin
            f = (b & c) | (~b & d); g = i;
         end else if (i < 32) begin
            f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
         end else if (i < 48) begin
            f = b ^ c ^ d; g = (3 * i + 5) % 16;
         end else begin
            f = c ^ (b | ~d); g = (7 * i) % 16;
         end
         s = a + f + k[i] + m[g];
         r = rot[((i / 16) * 4) + (i % 4)];
         t = (s << r) | (s >> (32 - r));
         a = d; d = c; c = b; b = b + t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
   endfunction

   // absorb one accepted item; on end of message queue the digest
   function void note_item(input logic [7:0] data, input logic has, input logic eom);
      logic [7:0] blk [64];
      logic [63:0] bits;
      int unsigned nblk;
      if (has) begin
         buffer[fill] = data;
         fill++;
         msg_len++;
         if (fill == 64) begin
            compress(buffer);
            fill = 0;
         end
      end
      if (!eom) return;
      nblk = (fill + 9 <= 64) ? 1 : 2;
      bits = msg_len << 3;
      for (int blkno = 0; blkno < nblk; blkno++) begin
         for (int j = 0; j < 64; j++) begin
            int unsigned p;
            p = blkno * 64 + j;
            if (p < fill) blk[j] = buffer[p];
            else if (p == fill) blk[j] = 8'h80;
            else if (p >= nblk * 64 - 8) blk[j] = bits[8*(p-(nblk*64-8)) +: 8];
            else blk[j] = 8'h00;
         end
         compress(blk);
      end
      for (int i = 0; i < 4; i++) begin
         digest_q.push_back(chain[i]);
         index_q.push_back(2'(i));
         last_q.push_back(i == 3);
      end
      restart();
   endfunction

   task report(input string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   task check_word(input logic [31:0] w, input logic [1:0] idx, input logic last);
      if (digest_q.size() == 0) begin
         report($sformatf("unexpected word %h", w));
         return;
      end
      if (w !== digest_q[0])
         report($sformatf("digest_word %h, expected %h", w, digest_q[0]));
      if (idx !== index_q[0])
         report($sformatf("word_index %0d, expected %0d", idx, index_q[0]));
      if (last !== last_q[0])
         report($sformatf("last_word %b, expected %b", last, last_q[0]));
      void'(digest_q.pop_front());
      void'(index_q.pop_front());
      void'(last_q.pop_front());
   endtask
endclass

module tb_md5_message_digest;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_has_byte = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [1:0]  rsp_word_index;
   logic        rsp_last_word;

   md5_digest_scoreboard digests = new();
   int unsigned hold_off = 0;   // receiver long stall, in cycles
   int unsigned rsp_gap = 0;    // receiver wait before the next item
   bit          send_done = 1'b0;

   always #2 clock = ~clock;

   md5_message_digest u_top (.*);

   // offer one item, with a random gap in front; valid stays up if no gap
   task automatic send_item(input logic [7:0] data, input logic has, input logic eom);
      int unsigned gap;
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_has_byte <= has;
      req_end_of_message <= eom;
      do @(posedge clock); while (!req_ready);
      digests.note_item(data, has, eom);
   endtask

   // a message of len random or all-ones bytes; the final byte optionally rides on the end item
   task automatic send_message(input int unsigned len, input bit byte_on_end,
                               input bit all_ones);
      int unsigned body;
      body = (byte_on_end && len > 0) ? len - 1 : len;
      for (int i = 0; i < body; i++) begin
         // occasional empty items that carry nothing
         if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
         send_item(all_ones ? 8'hff : 8'($urandom), 1'b1, 1'b0);
      end
      if (byte_on_end && len > 0) send_item(all_ones ? 8'hff : 8'($urandom), 1'b1, 1'b1);
      else send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   // receiver: random wait after each accepted item, plus the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= 0;
      end else begin
         if (rsp_valid && rsp_ready)
            digests.check_word(rsp_digest_word, rsp_word_index, rsp_last_word);
         if (hold_off != 0) begin
            hold_off <= hold_off - 1;
            rsp_ready <= 1'b0;
         end else if (rsp_valid && rsp_ready) begin
            int unsigned wait_cycles;
            wait_cycles = $urandom_range(0, 3);
            rsp_gap   <= wait_cycles;
            rsp_ready <= (wait_cycles == 0);
         end else if (rsp_gap != 0) begin
            rsp_gap   <= rsp_gap - 1;
            rsp_ready <= (rsp_gap == 1);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: empty, one byte on end, three all-ones bytes, two pad blocks, 64th byte with end
      send_message(0, 1'b0, 1'b0);
      send_message(1, 1'b1, 1'b0);
      send_message(3, 1'b0, 1'b1);
      send_message(56, 1'b0, 1'b0);
      send_message(64, 1'b1, 1'b0);
      // long receiver stall while messages keep coming: intake stalls behind the digest output
      hold_off = 400;
      send_message(2, 1'b1, 1'b0);
      send_message(0, 1'b0, 1'b0);
      send_message(5, 1'b0, 1'b0);
      // random short messages
      for (int n = 0; n < 3; n++)
         send_message($urandom_range(0, 6), 1'($urandom), 1'b0);
      req_valid <= 1'b0;
      wait (digests.digest_q.size() == 0);
      repeat (200) @(posedge clock);
      if (digests.errors == 0 && digests.digest_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end
endmodule
